/* design/cti_pkg.sv */
// Shared types and constants for the clamped table interpolator.
// No dependencies; every other file of the block imports this package.

package cti_pkg;

	// fixed field widths
	localparam int DATA_W = 32;
	localparam int ROW_W  = 4;
	localparam int PC_W   = 5;

	// item kinds
	localparam logic KIND_LOAD  = 1'b0;
	localparam logic KIND_QUERY = 1'b1;

	// result status codes
	localparam logic STATUS_OK    = 1'b0;
	localparam logic STATUS_ORDER = 1'b1;

	// blend unit operand tags
	localparam logic TAG_COND = 1'b0;
	localparam logic TAG_SPEC = 1'b1;

	// point count after reset
	localparam logic [PC_W-1:0] PC_RESET = 5'd2;

	typedef enum logic [3:0] {
		S_IDLE,
		S_WALK,
		S_CLASS,
		S_ROW0,
		S_ROW1,
		S_ROW2,
		S_DIV,
		S_MUL_C,
		S_MUL_S,
		S_MUL_W,
		S_DONE
	} cti_state_t;

	// control that travels with an operand pair through the blend unit
	typedef struct packed {
		logic valid;
		logic tag;
	} cti_blend_ctl_t;

endpackage

/* design/cti_if.sv */
// Handshake interfaces for the command and result channels.
// Depends on cti_pkg for the field widths.

interface cti_cmd_if import cti_pkg::*;;
	logic                     valid;
	logic                     ready;
	logic                     kind;
	logic [ROW_W-1:0]         row_index;
	logic signed [DATA_W-1:0] temperature;
	logic signed [DATA_W-1:0] conductivity_in;
	logic signed [DATA_W-1:0] specific_heat_in;

	modport source (
		output valid, kind, row_index, temperature, conductivity_in, specific_heat_in,
		input  ready
	);
	modport sink (
		input  valid, kind, row_index, temperature, conductivity_in, specific_heat_in,
		output ready
	);
endinterface

interface cti_rsp_if import cti_pkg::*;;
	logic                     valid;
	logic                     ready;
	logic signed [DATA_W-1:0] conductivity_out;
	logic signed [DATA_W-1:0] specific_heat_out;
	logic                     status;

	modport source (
		output valid, conductivity_out, specific_heat_out, status,
		input  ready
	);
	modport sink (
		input  valid, conductivity_out, specific_heat_out, status,
		output ready
	);
endinterface

/* design/clamped_table_linear_interp.sv */
// Clamped piecewise-linear interpolation table with two property columns.
// Uses cti_pkg, the cti_cmd_if / cti_rsp_if interfaces, cti_div and cti_blend.
//
// Usage:
//   cmd carries one transaction per item. kind 0 writes row row_index of the
//   breakpoint table (temperature, conductivity, specific heat) and gives no
//   result. kind 1 queries at a temperature and gives one rsp
//   transaction: both properties and a status, status 1 with zero values
//   when the breakpoints in use are not strictly increasing.
//   cfg_we/cfg_wdata write point_count (rows in use, clamped to 2..MAX_POINTS);
//   write it only while no query is in flight.
// Operation:
//   a query walks the n rows in use through the single read port of the
//   table. An interpolating query then reads two rows and runs the
//   one-bit-per-cycle divider and the shared three-stage blend unit. A
//   clamped query reads one row and skips both units; an order error reads
//   no row. cmd.ready is low while a query is being worked on.
// Reset: point_count returns to 2 and the control clears; table contents
//   stay undefined until written.
// Stall: a result waits in the output register; the next item may be taken
//   meanwhile, and a following query holds at its end until the register frees.

module clamped_table_linear_interp import cti_pkg::*; #(
	parameter int MAX_POINTS = 16,
	parameter int FRAC_BITS  = 16
) (
	input  logic            clk,
	input  logic            arst_n,
	cti_cmd_if.sink         cmd,
	cti_rsp_if.source       rsp,
	input  logic            cfg_we,
	input  logic [PC_W-1:0] cfg_wdata
);

	localparam int IDX_W = $clog2(MAX_POINTS);
	localparam int CNT_W = $clog2(MAX_POINTS + 1);

	// table storage
	logic [DATA_W-1:0] t_mem [MAX_POINTS];
	logic [DATA_W-1:0] c_mem [MAX_POINTS];
	logic [DATA_W-1:0] s_mem [MAX_POINTS];
	logic [DATA_W-1:0] t_rd_q, c_rd_q, s_rd_q;

	cti_state_t state_q, state_d;

	logic [PC_W-1:0]   pc_q;
	logic [CNT_W-1:0]  n_c, n_q, w_q;
	logic [IDX_W-1:0]  last, seg_q, base_q, rd_addr, wr_addr;
	logic [DATA_W-1:0] t_q, t0_q, prev_q, lo_q, hi_q;
	logic              err_q, found_q, clamp_q;
	logic              at_low, at_high;
	logic [DATA_W-1:0] v1c_q, v1s_q, v2c_q, v2s_q;
	logic [DATA_W-1:0] res_c_q, res_s_q;
	logic              res_st_q;
	logic              rsp_valid_q, rsp_st_q;
	logic [DATA_W-1:0] rsp_c_q, rsp_s_q;

	logic cmd_fire, load_we, query_go, out_load, div_start, div_busy;
	logic [FRAC_BITS:0] alpha;
	cti_blend_ctl_t     blend_ctl, blend_out;
	logic [DATA_W-1:0]  blend_v1, blend_v2, blend_res;

	// command handshake and table write
	assign cmd.ready = (state_q == S_IDLE);
	assign cmd_fire  = cmd.valid && cmd.ready;
	assign load_we   = cmd_fire && (cmd.kind == KIND_LOAD)
		&& (32'(cmd.row_index) < 32'(MAX_POINTS));
	assign query_go  = cmd_fire && (cmd.kind == KIND_QUERY);
	assign wr_addr   = IDX_W'(cmd.row_index);

	always_ff @(posedge clk) begin
		if (load_we) begin
			t_mem[wr_addr] <= cmd.temperature;
			c_mem[wr_addr] <= cmd.conductivity_in;
			s_mem[wr_addr] <= cmd.specific_heat_in;
		end
		t_rd_q <= t_mem[rd_addr];
		c_rd_q <= c_mem[rd_addr];
		s_rd_q <= s_mem[rd_addr];
	end

	// rows in use, clamped
	always_comb begin
		if (pc_q < PC_W'(2))
			n_c = CNT_W'(2);
		else if (32'(pc_q) > 32'(MAX_POINTS))
			n_c = CNT_W'(MAX_POINTS);
		else
			n_c = CNT_W'(pc_q);
	end

	assign last    = IDX_W'(n_q - CNT_W'(1));
	assign at_low  = $signed(t_q) <= $signed(t0_q);
	assign at_high = $signed(t_q) >= $signed(prev_q);

	// sequencer
	always_comb begin
		state_d   = state_q;
		rd_addr   = '0;
		div_start = 1'b0;
		blend_ctl = '0;
		out_load  = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (query_go)
					state_d = S_WALK;
			end
			S_WALK: begin
				if (w_q < n_q)
					rd_addr = IDX_W'(w_q);
				if (w_q == n_q)
					state_d = S_CLASS;
			end
			S_CLASS: begin
				if (err_q)
					state_d = S_DONE;
				else begin
					div_start = !(at_low || at_high);
					state_d   = S_ROW0;
				end
			end
			S_ROW0: begin
				rd_addr = base_q;
				state_d = S_ROW1;
			end
			S_ROW1: begin
				if (clamp_q)
					state_d = S_DONE;
				else begin
					rd_addr = base_q + IDX_W'(1);
					state_d = S_ROW2;
				end
			end
			S_ROW2: begin
				state_d = S_DIV;
			end
			S_DIV: begin
				if (!div_busy)
					state_d = S_MUL_C;
			end
			S_MUL_C: begin
				blend_ctl.valid = 1'b1;
				blend_ctl.tag   = TAG_COND;
				state_d         = S_MUL_S;
			end
			S_MUL_S: begin
				blend_ctl.valid = 1'b1;
				blend_ctl.tag   = TAG_SPEC;
				state_d         = S_MUL_W;
			end
			S_MUL_W: begin
				if (blend_out.valid && blend_out.tag == TAG_SPEC)
					state_d = S_DONE;
			end
			S_DONE: begin
				if (!rsp_valid_q || rsp.ready) begin
					out_load = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else
			state_q <= state_d;
	end

	// config register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			pc_q <= PC_RESET;
		else if (cfg_we)
			pc_q <= cfg_wdata;
	end

	// walk control and flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_q     <= '0;
			err_q   <= 1'b0;
			found_q <= 1'b0;
			clamp_q <= 1'b0;
		end else begin
			if (query_go) begin
				w_q     <= '0;
				err_q   <= 1'b0;
				found_q <= 1'b0;
			end else if (state_q == S_WALK) begin
				w_q <= w_q + CNT_W'(1);
				if (w_q > CNT_W'(1)) begin
					if ($signed(t_rd_q) <= $signed(prev_q))
						err_q <= 1'b1;
					if (!found_q && $signed(t_q) <= $signed(t_rd_q))
						found_q <= 1'b1;
				end
			end
			if (state_q == S_CLASS)
				clamp_q <= at_low || at_high;
		end
	end

	// walk data: first breakpoint, previous breakpoint, bracketing interval
	always_ff @(posedge clk) begin
		if (query_go) begin
			t_q <= cmd.temperature;
			n_q <= n_c;
		end
		if (state_q == S_WALK && w_q != '0) begin
			prev_q <= t_rd_q;
			if (w_q == CNT_W'(1))
				t0_q <= t_rd_q;
			else if (!found_q && $signed(t_q) <= $signed(t_rd_q)) begin
				seg_q <= IDX_W'(w_q - CNT_W'(2));
				lo_q  <= prev_q;
				hi_q  <= t_rd_q;
			end
		end
	end

	// row select and result collection
	always_ff @(posedge clk) begin
		if (state_q == S_CLASS) begin
			res_st_q <= err_q ? STATUS_ORDER : STATUS_OK;
			if (err_q) begin
				res_c_q <= '0;
				res_s_q <= '0;
			end
			if (at_low)
				base_q <= '0;
			else if (at_high)
				base_q <= last;
			else
				base_q <= seg_q;
		end
		if (state_q == S_ROW1) begin
			v1c_q <= c_rd_q;
			v1s_q <= s_rd_q;
			if (clamp_q) begin
				res_c_q <= c_rd_q;
				res_s_q <= s_rd_q;
			end
		end
		if (state_q == S_ROW2) begin
			v2c_q <= c_rd_q;
			v2s_q <= s_rd_q;
		end
		if (blend_out.valid) begin
			if (blend_out.tag == TAG_SPEC)
				res_s_q <= blend_res;
			else
				res_c_q <= blend_res;
		end
	end

	// shared arithmetic units
	cti_div #(.FRAC_BITS(FRAC_BITS)) u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (div_start),
		.num   (t_q - lo_q),
		.den   (hi_q - lo_q),
		.busy  (div_busy),
		.alpha (alpha)
	);

	assign blend_v1 = (blend_ctl.tag == TAG_SPEC) ? v1s_q : v1c_q;
	assign blend_v2 = (blend_ctl.tag == TAG_SPEC) ? v2s_q : v2c_q;

	cti_blend #(.FRAC_BITS(FRAC_BITS)) u_blend (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (blend_ctl),
		.alpha  (alpha),
		.v1     (blend_v1),
		.v2     (blend_v2),
		.out_ctl(blend_out),
		.res    (blend_res)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			rsp_valid_q <= 1'b0;
		else if (out_load)
			rsp_valid_q <= 1'b1;
		else if (rsp.ready)
			rsp_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			rsp_c_q  <= res_c_q;
			rsp_s_q  <= res_s_q;
			rsp_st_q <= res_st_q;
		end
	end

	assign rsp.valid             = rsp_valid_q;
	assign rsp.conductivity_out  = rsp_c_q;
	assign rsp.specific_heat_out = rsp_s_q;
	assign rsp.status            = rsp_st_q;

	// checks
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.status == STATUS_ORDER
		|-> rsp.conductivity_out == '0 && rsp.specific_heat_out == '0)
		else $error("order error result carries nonzero values");

	a_div_idle: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> !div_busy)
		else $error("divider restarted while busy");

	a_walk_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_WALK |-> w_q <= n_q)
		else $error("breakpoint walk ran past rows in use");

	a_rows_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != S_IDLE |-> n_q >= CNT_W'(2) && n_q <= CNT_W'(MAX_POINTS))
		else $error("rows in use out of range");

	a_blend_phase: assert property (@(posedge clk) disable iff (!arst_n)
		blend_out.valid && blend_out.tag == TAG_SPEC |-> state_q == S_MUL_W)
		else $error("blend result outside collection phase");

endmodule

/* design/cti_div.sv */
// Restoring divider, one quotient bit per cycle, for the interpolation fraction.
// Computes (num << FRAC_BITS) / den for num <= den. Depends on cti_pkg.

module cti_div import cti_pkg::*; #(
	parameter int FRAC_BITS = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [DATA_W-1:0] num,
	input  logic [DATA_W-1:0] den,
	output logic              busy,
	output logic [FRAC_BITS:0] alpha
);

	localparam int Q_W   = FRAC_BITS + 1;
	localparam int CNT_W = $clog2(Q_W + 1);

	logic [DATA_W:0]   rem_q;
	logic [DATA_W-1:0] den_q;
	logic [Q_W-1:0]    quo_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              busy_q;

	logic [DATA_W+1:0] trial;
	logic              ge;
	logic [DATA_W:0]   rem_keep;
	logic [DATA_W:0]   rem_nxt;

	// trial subtract and shift
	always_comb begin
		trial    = {1'b0, rem_q} - {2'b00, den_q};
		ge       = ~trial[DATA_W+1];
		rem_keep = ge ? trial[DATA_W:0] : rem_q;
		rem_nxt  = {rem_keep[DATA_W-1:0], 1'b0};
	end

	// iteration control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + CNT_W'(1);
			if (cnt_q == CNT_W'(Q_W - 1))
				busy_q <= 1'b0;
		end
	end

	// remainder and quotient
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= {1'b0, num};
			den_q <= den;
		end else if (busy_q) begin
			rem_q <= rem_nxt;
			quo_q <= {quo_q[Q_W-2:0], ge};
		end
	end

	assign busy  = busy_q;
	assign alpha = quo_q;

endmodule

/* design/cti_blend.sv */
// Three-stage blend unit: v1 + trunc(alpha * (v2 - v1) / 2^FRAC_BITS).
// Shared by both property columns, one operand pair per cycle. Depends on cti_pkg.

module cti_blend import cti_pkg::*; #(
	parameter int FRAC_BITS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  cti_blend_ctl_t     ctl,
	input  logic [FRAC_BITS:0] alpha,
	input  logic [DATA_W-1:0]  v1,
	input  logic [DATA_W-1:0]  v2,
	output cti_blend_ctl_t     out_ctl,
	output logic [DATA_W-1:0]  res
);

	localparam int A_W = FRAC_BITS + 1;
	localparam int P_W = A_W + DATA_W;

	logic [DATA_W:0] dv;
	logic [DATA_W:0] mag_full;

	cti_blend_ctl_t    ctl_s1, ctl_s2, ctl_s3;
	logic [DATA_W-1:0] mag_s1;
	logic              neg_s1, neg_s2;
	logic [DATA_W-1:0] v1_s1, v1_s2;
	logic [A_W-1:0]    alpha_s1;
	logic [P_W-1:0]    prod_s2;
	logic [DATA_W-1:0] res_s3;
	logic [DATA_W-1:0] step;

	// signed difference and its magnitude
	always_comb begin
		dv       = {v2[DATA_W-1], v2} - {v1[DATA_W-1], v1};
		mag_full = dv[DATA_W] ? (~dv + (DATA_W+1)'(1)) : dv;
		step     = prod_s2[FRAC_BITS +: DATA_W];
	end

	// stage valid and tag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
			ctl_s3 <= '0;
		end else begin
			ctl_s1 <= ctl;
			ctl_s2 <= ctl_s1;
			ctl_s3 <= ctl_s2;
		end
	end

	// datapath stages
	always_ff @(posedge clk) begin
		mag_s1   <= mag_full[DATA_W-1:0];
		neg_s1   <= dv[DATA_W];
		v1_s1    <= v1;
		alpha_s1 <= alpha;

		prod_s2 <= P_W'(alpha_s1) * P_W'(mag_s1);
		neg_s2  <= neg_s1;
		v1_s2   <= v1_s1;

		res_s3 <= neg_s2 ? (v1_s2 - step) : (v1_s2 + step);
	end

	assign out_ctl = ctl_s3;
	assign res     = res_s3;

endmodule

/* bench/tb.sv */
// Testbench for clamped_table_linear_interp: loads breakpoint rows, queries at
// directed and random temperatures; each answer must match a listed or predicted value.
// Depends on cti_pkg, the cti_cmd_if / cti_rsp_if interfaces and the block itself.

module tb;
	import cti_pkg::*;

	localparam int TABLE_ROWS   = 16;
	localparam int FRAC         = 16;
	localparam int ITEM_TARGET  = 400;
	localparam int DRAIN_CYCLES = 50;
	localparam int HOLD_CYCLES  = 400;
	localparam int CYCLE_LIMIT  = 500000;
	localparam int N_DIRECTED   = 24;
	localparam int REPORT_MAX   = 10;

	typedef struct packed {
		logic                     kind;
		logic [ROW_W-1:0]         row;
		logic signed [DATA_W-1:0] temp;
		logic signed [DATA_W-1:0] cond;
		logic signed [DATA_W-1:0] spec;
	} cmd_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] cond;
		logic signed [DATA_W-1:0] spec;
		logic                     status;
	} prop_t;

	typedef struct packed {
		cmd_t  c;
		logic  typed;
		prop_t want;
	} dir_row_t;

	// directed transactions: extremes, clamps at both ends, order errors
	localparam dir_row_t DIRECTED [N_DIRECTED] = '{
		'{'{KIND_LOAD, 4'd0, 32'hffff_0000, 32'h0001_0000, 32'h7fff_ffff}, 1'b0, '0},
		'{'{KIND_LOAD, 4'd1, 32'h0001_0000, 32'h0003_0000, 32'h8000_0000}, 1'b0, '0},
		'{'{KIND_QUERY, 4'd0, 32'h8000_0000, 32'h0, 32'h0}, 1'b1,
			'{32'h0001_0000, 32'h7fff_ffff, STATUS_OK}},
		'{'{KIND_QUERY, 4'd0, 32'h7fff_ffff, 32'h0, 32'h0}, 1'b1,
			'{32'h0003_0000, 32'h8000_0000, STATUS_OK}},
		'{'{KIND_QUERY, 4'd0, 32'hffff_0000, 32'h0, 32'h0}, 1'b1,
			'{32'h0001_0000, 32'h7fff_ffff, STATUS_OK}},
		'{'{KIND_QUERY, 4'd0, 32'h0001_0000, 32'h0, 32'h0}, 1'b1,
			'{32'h0003_0000, 32'h8000_0000, STATUS_OK}},
		'{'{KIND_QUERY, 4'd0, 32'h0000_0000, 32'h0, 32'h0}, 1'b0, '0},
		'{'{KIND_QUERY, 4'd0, 32'hffff_0001, 32'h0, 32'h0}, 1'b0, '0},
		'{'{KIND_QUERY, 4'd0, 32'h0000_ffff, 32'h0, 32'h0}, 1'b0, '0},
		'{'{KIND_LOAD, 4'd1, 32'hffff_0000, 32'hffff_ffff, 32'h0000_0000}, 1'b0, '0},
		'{'{KIND_QUERY, 4'd0, 32'h0000_0000, 32'h0, 32'h0}, 1'b1,
			'{32'h0, 32'h0, STATUS_ORDER}},
		'{'{KIND_LOAD, 4'd1, 32'hfffe_0000, 32'h0000_0000, 32'hffff_ffff}, 1'b0, '0},
		'{'{KIND_QUERY, 4'd0, 32'hffff_ffff, 32'h0, 32'h0}, 1'b1,
			'{32'h0, 32'h0, STATUS_ORDER}},
		'{'{KIND_LOAD, 4'd0, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff}, 1'b0, '0},
		'{'{KIND_LOAD, 4'd1, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000}, 1'b0, '0},
		'{'{KIND_QUERY, 4'd0, 32'h8000_0000, 32'h0, 32'h0}, 1'b1,
			'{32'h8000_0000, 32'h7fff_ffff, STATUS_OK}},
		'{'{KIND_QUERY, 4'd0, 32'h7fff_ffff, 32'h0, 32'h0}, 1'b1,
			'{32'h7fff_ffff, 32'h8000_0000, STATUS_OK}},
		'{'{KIND_QUERY, 4'd0, 32'h0000_0000, 32'h0, 32'h0}, 1'b0, '0},
		'{'{KIND_QUERY, 4'd0, 32'h7fff_fffe, 32'h0, 32'h0}, 1'b0, '0},
		'{'{KIND_QUERY, 4'd0, 32'h8000_0001, 32'h0, 32'h0}, 1'b0, '0},
		'{'{KIND_LOAD, 4'd0, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000}, 1'b0, '0},
		'{'{KIND_LOAD, 4'd1, 32'h0000_0001, 32'hffff_ffff, 32'h7fff_ffff}, 1'b0, '0},
		'{'{KIND_QUERY, 4'd0, 32'h0000_0000, 32'h0, 32'h0}, 1'b1,
			'{32'h0, 32'h0, STATUS_OK}},
		'{'{KIND_QUERY, 4'd0, 32'h0000_0001, 32'h0, 32'h0}, 1'b1,
			'{32'hffff_ffff, 32'h7fff_ffff, STATUS_OK}}
	};

	logic            clk = 1'b0;
	logic            arst_n;
	logic            cfg_we;
	logic [PC_W-1:0] cfg_wdata;

	cti_cmd_if cmd_ch ();
	cti_rsp_if rsp_ch ();

	clamped_table_linear_interp #(
		.MAX_POINTS (TABLE_ROWS),
		.FRAC_BITS  (FRAC)
	) u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd_ch),
		.rsp       (rsp_ch),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	always #5 clk = ~clk;

	// shadow copy of the breakpoint table and the row count
	logic signed [DATA_W-1:0] bp_temp [TABLE_ROWS];
	logic signed [DATA_W-1:0] bp_cond [TABLE_ROWS];
	logic signed [DATA_W-1:0] bp_spec [TABLE_ROWS];
	logic [PC_W-1:0]          pc_shadow;

	prop_t pending_props [$];
	prop_t head_props;

	bit quiet;
	bit hold_request;
	int hold_left;
	int stall_left;
	int cycle_count;
	int items_sent;
	int queries_sent;
	int results_seen;
	int order_flags;
	int settings_seen;
	int mismatches;

	// rows in use after clamping the count to 2..TABLE_ROWS
	function automatic int rows_active();
		if (pc_shadow < 2) return 2;
		if (pc_shadow > TABLE_ROWS) return TABLE_ROWS;
		return int'(pc_shadow);
	endfunction

	// lo + trunc(alpha * (hi - lo) / 2^FRAC)
	function automatic logic signed [DATA_W-1:0] blend_prop(
		input logic signed [DATA_W-1:0] lo,
		input logic signed [DATA_W-1:0] hi,
		input logic [63:0]              alpha
	);
		longint      dv;
		logic [63:0] mag;
		logic [63:0] step;
		longint      res;
		dv   = longint'(hi) - longint'(lo);
		mag  = (dv < 0) ? 64'(-dv) : 64'(dv);
		step = (alpha * mag) >> FRAC;
		res  = (dv < 0) ? longint'(lo) - longint'(step) : longint'(lo) + longint'(step);
		return res[DATA_W-1:0];
	endfunction

	// expected answer of a query against the shadow table
	function automatic prop_t interp_lookup(input logic signed [DATA_W-1:0] t);
		prop_t       r;
		int          n;
		int          last;
		int          i;
		longint      tq;
		longint      t1;
		longint      t2;
		logic [63:0] alpha;
		r    = '0;
		n    = rows_active();
		last = n - 1;
		tq   = longint'(t);
		for (i = 1; i < n; i++) begin
			if (bp_temp[i] <= bp_temp[i-1]) begin
				r.status = STATUS_ORDER;
				return r;
			end
		end
		r.status = STATUS_OK;
		if (tq <= longint'(bp_temp[0])) begin
			r.cond = bp_cond[0];
			r.spec = bp_spec[0];
			return r;
		end
		if (tq >= longint'(bp_temp[last])) begin
			r.cond = bp_cond[last];
			r.spec = bp_spec[last];
			return r;
		end
		for (i = 0; i < last; i++) begin
			t1 = longint'(bp_temp[i]);
			t2 = longint'(bp_temp[i+1]);
			if (tq >= t1 && tq <= t2) begin
				alpha  = (64'(tq - t1) << FRAC) / 64'(t2 - t1);
				r.cond = blend_prop(bp_cond[i], bp_cond[i+1], alpha);
				r.spec = blend_prop(bp_spec[i], bp_spec[i+1], alpha);
				return r;
			end
		end
		r.cond = bp_cond[last];
		r.spec = bp_spec[last];
		return r;
	endfunction

	// mostly short gaps, a few long ones, none in quiet stretches
	function automatic int idle_len();
		int r;
		if (quiet) return 0;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 88) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// property value: full range or a narrower spread
	function automatic logic signed [DATA_W-1:0] rand_prop();
		if ($urandom_range(0, 1) == 0) return $urandom;
		return int'($urandom) >>> $urandom_range(1, 24);
	endfunction

	task automatic note_mismatch(input string msg);
		mismatches++;
		if (mismatches <= REPORT_MAX) $display("tb: mismatch: %s", msg);
	endtask

	// offer one transaction and update the shadow state once it is taken
	task automatic send_cmd(input cmd_t c, input logic typed, input prop_t want);
		cmd_ch.valid            <= 1'b1;
		cmd_ch.kind             <= c.kind;
		cmd_ch.row_index        <= c.row;
		cmd_ch.temperature      <= c.temp;
		cmd_ch.conductivity_in  <= c.cond;
		cmd_ch.specific_heat_in <= c.spec;
		@(posedge clk);
		while (!cmd_ch.ready) @(posedge clk);
		items_sent++;
		if (c.kind == KIND_LOAD) begin
			bp_temp[c.row] = c.temp;
			bp_cond[c.row] = c.cond;
			bp_spec[c.row] = c.spec;
		end else begin
			queries_sent++;
			pending_props.insert(pending_props.size(),
				typed ? want : interp_lookup(c.temp));
		end
	endtask

	task automatic pause_sender(input int cycles);
		if (cycles > 0) begin
			cmd_ch.valid <= 1'b0;
			repeat (cycles) @(posedge clk);
		end
	endtask

	// row count changes only once all answers are back and the block is idle
	task automatic write_point_count(input logic [PC_W-1:0] v);
		cmd_ch.valid <= 1'b0;
		while (pending_props.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we    <= 1'b0;
		pc_shadow = v;
		settings_seen++;
	endtask

	// answer checking and ready pacing with random stalls and one long hold
	always @(posedge clk) begin
		if (rsp_ch.valid && rsp_ch.ready) begin
			if (pending_props.size() == 0) begin
				note_mismatch($sformatf("unexpected answer cond %h spec %h status %0d",
					rsp_ch.conductivity_out, rsp_ch.specific_heat_out, rsp_ch.status));
			end else begin
				head_props = pending_props.pop_front();
				results_seen++;
				if (head_props.status == STATUS_ORDER) order_flags++;
				if (rsp_ch.conductivity_out !== head_props.cond
						|| rsp_ch.specific_heat_out !== head_props.spec
						|| rsp_ch.status !== head_props.status)
					note_mismatch($sformatf(
						"answer %0d cond exp %h got %h, spec exp %h got %h, status exp %0d got %0d",
						results_seen, head_props.cond, rsp_ch.conductivity_out,
						head_props.spec, rsp_ch.specific_heat_out,
						head_props.status, rsp_ch.status));
			end
		end
		if (hold_request) begin
			hold_left    = HOLD_CYCLES;
			hold_request = 1'b0;
		end
		if (hold_left > 0) begin
			hold_left--;
			rsp_ch.ready <= 1'b0;
		end else if (quiet) begin
			rsp_ch.ready <= 1'b1;
		end else if (stall_left > 0) begin
			stall_left--;
			rsp_ch.ready <= 1'b0;
		end else if ($urandom_range(0, 99) < 25) begin
			stall_left = idle_len();
			rsp_ch.ready <= 1'b0;
		end else begin
			rsp_ch.ready <= 1'b1;
		end
	end

	// run limit
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("tb: timeout after %0d cycles, %0d answers outstanding",
				cycle_count, pending_props.size());
			$display("tb: errors");
			$finish;
		end
	end

	// stimulus
	initial begin
		int          pc_val;
		int          n;
		int          shift;
		int          phase;
		int          burst;
		int          pick;
		int          k;
		cmd_t        c;
		int          temps_q [$];
		int          order_q [$];
		logic [63:0] rnd64;
		longint      lo;
		longint      hi;
		longint      tq;

		arst_n                  <= 1'b0;
		cmd_ch.valid            <= 1'b0;
		cmd_ch.kind             <= KIND_LOAD;
		cmd_ch.row_index        <= '0;
		cmd_ch.temperature      <= '0;
		cmd_ch.conductivity_in  <= '0;
		cmd_ch.specific_heat_in <= '0;
		cfg_we                  <= 1'b0;
		cfg_wdata               <= '0;
		pc_shadow = PC_RESET;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part at the reset row count
		for (k = 0; k < N_DIRECTED; k++) begin
			send_cmd(DIRECTED[k].c, DIRECTED[k].typed, DIRECTED[k].want);
			pause_sender(idle_len());
		end

		// random phases: new row count, fresh sorted table, then mixed traffic
		phase = 0;
		while (items_sent < ITEM_TARGET) begin
			case (phase)
				0:       pc_val = 16;
				1:       pc_val = 0;
				2:       pc_val = 31;
				3:       pc_val = 1;
				4:       pc_val = 17;
				5:       pc_val = 2;
				default: pc_val = $urandom_range(0, 31);
			endcase
			write_point_count(pc_val[PC_W-1:0]);
			quiet = (phase % 4 == 2) || (phase == 3);
			// long receiver hold while the sender keeps offering
			if (phase == 3) hold_request = 1'b1;
			n = rows_active();

			// strictly increasing breakpoints, wide or narrow spread
			shift = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 28);
			temps_q.delete();
			order_q.delete();
			for (k = 0; k < n; k++) begin
				temps_q.insert(temps_q.size(), int'($urandom) >>> shift);
				order_q.insert(order_q.size(), k);
			end
			temps_q.sort();
			for (k = 1; k < n; k++) begin
				if (temps_q[k] <= temps_q[k-1]) temps_q[k] = temps_q[k-1] + 1;
			end
			// now and then a table with a repeated breakpoint
			if ($urandom_range(0, 7) == 0) temps_q[n/2] = temps_q[n/2 - 1];
			order_q.shuffle();
			foreach (order_q[j]) begin
				c.kind = KIND_LOAD;
				c.row  = ROW_W'(order_q[j]);
				c.temp = temps_q[order_q[j]];
				c.cond = rand_prop();
				c.spec = rand_prop();
				send_cmd(c, 1'b0, '0);
				pause_sender(idle_len());
			end

			burst = $urandom_range(12, 24);
			repeat (burst) begin
				pick   = $urandom_range(0, 99);
				c      = '0;
				c.kind = KIND_QUERY;
				k      = $urandom_range(0, n - 1);
				if (pick < 45) begin
					// inside the table span
					lo    = longint'(bp_temp[0]);
					hi    = longint'(bp_temp[n-1]);
					rnd64 = {$urandom, $urandom};
					if (hi > lo) begin
						tq     = lo + longint'(rnd64 % 64'(hi - lo + 1));
						c.temp = tq[DATA_W-1:0];
					end else begin
						c.temp = $urandom;
					end
				end else if (pick < 58) begin
					c.temp = bp_temp[k];
				end else if (pick < 66) begin
					c.temp = bp_temp[k] + DATA_W'($urandom_range(0, 4)) - DATA_W'(2);
				end else if (pick < 78) begin
					// new values, same breakpoint
					c.kind = KIND_LOAD;
					c.row  = ROW_W'(k);
					c.temp = bp_temp[k];
					c.cond = rand_prop();
					c.spec = rand_prop();
				end else if (pick < 86) begin
					// any row, any breakpoint: may break the ordering
					c.kind = KIND_LOAD;
					c.row  = ROW_W'($urandom_range(0, TABLE_ROWS - 1));
					c.temp = $urandom;
					c.cond = rand_prop();
					c.spec = rand_prop();
				end else begin
					c.temp = $urandom;
				end
				send_cmd(c, 1'b0, '0);
				pause_sender(idle_len());
			end
			phase++;
		end

		// drain and let the block settle
		cmd_ch.valid <= 1'b0;
		while (pending_props.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("tb: %0d transactions in (%0d queries), %0d answers checked, %0d row counts",
			items_sent, queries_sent, results_seen, settings_seen);
		$display("tb: %0d answers flagged out of order, %0d mismatches",
			order_flags, mismatches);
		if (mismatches == 0) begin
			$display("tb: clean");
		end else begin
			$display("tb: errors");
		end
		$finish;
	end

endmodule

/* clamped_table_linear_interp.f */
design/cti_pkg.sv
design/cti_if.sv
design/cti_div.sv
design/cti_blend.sv
design/clamped_table_linear_interp.sv
bench/tb.sv
